// ----- hdl/per_client_bandwidth_share_assert.svh -----
// Assertion macros used by the checker file.
`ifndef PER_CLIENT_BANDWIDTH_SHARE_ASSERT_SVH
`define PER_CLIENT_BANDWIDTH_SHARE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PCBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication with the consequent checked in the cycle after the antecedent.
`define PCBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- hdl/pcbs_pkg.sv -----
// Shared types, constants and helpers for the bandwidth share block.
package pcbs_pkg;
	localparam int MAX_CLIENTS = 16;
	localparam int IDLE_SECONDS = 3;
	localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int CNT_W = $clog2(MAX_CLIENTS + 1);
	localparam int QDEPTH = 2;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_USE = 1'b1;

	// One queued beat from the front to the back.
	typedef struct packed {
		logic        action;
		logic [31:0] now_seconds;
		logic [47:0] key;
		logic [31:0] want;
	} cmd_t;

	// Saturating 32-bit add.
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction
endpackage

// ----- hdl/pcbs_front.sv -----
// Front end: takes commands and queues them for the back end.
module pcbs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          action,
	input  logic [31:0]   now_seconds,
	input  logic [31:0]   client_addr,
	input  logic [15:0]   client_port,
	input  logic [31:0]   want,
	output logic          busy,
	output logic          q_valid,
	output pcbs_pkg::cmd_t q_data,
	input  logic          q_pop
);
	pcbs_pkg::cmd_t mem_q [pcbs_pkg::QDEPTH];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push;

	assign busy = (cnt_q == 2'(pcbs_pkg::QDEPTH));
	assign push = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{action: action, now_seconds: now_seconds,
				key: {client_addr, client_port}, want: want};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

// ----- hdl/pcbs_div.sv -----
// Restoring divider, one quotient bit per cycle.
module pcbs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [33:0] dividend,
	input  logic [33:0] divisor,
	output logic        done,
	output logic [33:0] quotient
);
	logic [33:0] rem_q, quo_q, div_q;
	logic [5:0] cnt_q;
	logic run_q;
	logic [34:0] trial;
	logic [33:0] rsh;

	assign rsh = {rem_q[32:0], quo_q[33]};
	assign trial = {1'b0, rsh} - {1'b0, div_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 6'd34;
				rem_q <= '0;
				quo_q <= dividend;
				div_q <= divisor;
			end else if (run_q) begin
				if (trial[34]) begin
					rem_q <= rsh;
					quo_q <= {quo_q[32:0], 1'b0};
				end else begin
					rem_q <= trial[33:0];
					quo_q <= {quo_q[32:0], 1'b1};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

// ----- hdl/pcbs_back.sv -----
// Back end: client table, pool, history and result generation.
module pcbs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [31:0]    max_share,
	input  logic           q_valid,
	input  pcbs_pkg::cmd_t q_data,
	output logic           q_pop,
	output logic           done,
	output logic [31:0]    granted,
	output logic [31:0]    usage_average,
	output logic           table_full
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_SWEEP, ST_QDIV, ST_USE, ST_AVG, ST_AVG2, ST_DONE
	} state_t;

	state_t state_q;
	pcbs_pkg::cmd_t cmd_q;
	logic [pcbs_pkg::MAX_CLIENTS-1:0] valid_q;
	logic [47:0] key_q [pcbs_pkg::MAX_CLIENTS];
	logic [31:0] stamp_q [pcbs_pkg::MAX_CLIENTS];
	logic [31:0] quota_q [pcbs_pkg::MAX_CLIENTS];
	logic [31:0] pool_q, sec_q, quota_val_q, grant_q, avg_q;
	logic [31:0] hist_q [3];
	logic full_q;
	logic [16:0] avg_hi_s1;
	logic [18:0] avg_lo_s1;

	logic div_go, div_done;
	logic [33:0] div_a, div_b, div_res;

	pcbs_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quotient(div_res)
	);

	// Match and free-slot search over the table.
	logic hit;
	logic free_found;
	logic [pcbs_pkg::IDX_W-1:0] hit_idx, free_idx;
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		free_found = 1'b0;
		free_idx = '0;
		for (int i = pcbs_pkg::MAX_CLIENTS - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == cmd_q.key) begin
				hit = 1'b1;
				hit_idx = pcbs_pkg::IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx = pcbs_pkg::IDX_W'(i);
			end
		end
	end

	// Idle sweep applies to the new second held in sec_q.
	logic [pcbs_pkg::MAX_CLIENTS-1:0] keep;
	always_comb begin
		for (int i = 0; i < pcbs_pkg::MAX_CLIENTS; i++) begin
			keep[i] = valid_q[i] &&
				((sec_q - stamp_q[i]) <= 32'(pcbs_pkg::IDLE_SECONDS));
		end
	end

	logic [pcbs_pkg::CNT_W-1:0] keep_cnt;
	assign keep_cnt = pcbs_pkg::CNT_W'($countones(keep));

	// Grant arithmetic for the selected entry.
	logic [pcbs_pkg::IDX_W-1:0] slot;
	logic [31:0] old_quota, from_pool, qsum, use_amt;
	assign slot = hit ? hit_idx : free_idx;
	assign old_quota = hit ? quota_q[hit_idx] : 32'd0;
	assign from_pool = (pool_q < cmd_q.want) ? pool_q : cmd_q.want;
	assign qsum = pcbs_pkg::sat_add(old_quota, from_pool);
	assign use_amt = (cmd_q.want < qsum) ? cmd_q.want : qsum;

	// A tenth of the share as a reciprocal product, exact for 32-bit inputs.
	logic [63:0] tenth_prod;
	assign tenth_prod = {32'b0, max_share} * 64'hCCCC_CCCD;

	logic [33:0] hsum;
	assign hsum = {2'b0, hist_q[0]} + {2'b0, hist_q[1]} + {2'b0, hist_q[2]};

	// The average divides by three in two steps: first the upper 17 bits,
	// then their remainder joined to the lower 17 bits.
	logic [34:0] hi_prod;
	logic [16:0] hi_quo;
	logic [1:0] hi_rem;
	logic [38:0] lo_prod;
	logic [33:0] avg_sum;
	assign hi_prod = {18'b0, hsum[33:17]} * 35'h1_5556;
	assign hi_quo = hi_prod[34:18];
	assign hi_rem = hsum[18:17] - {hi_quo[0], 1'b0} - hi_quo[1:0];
	assign lo_prod = {20'b0, avg_lo_s1} * 39'h5_5556;
	assign avg_sum = {avg_hi_s1, 17'b0} + {15'b0, lo_prod[38:20]};

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign usage_average = avg_q;
	assign granted = grant_q;
	assign table_full = full_q;
	assign done = (state_q == ST_DONE);

	assign div_go = (state_q == ST_SWEEP) && (keep_cnt != '0);
	assign div_a = {2'b0, quota_val_q};
	assign div_b = 34'(keep_cnt);

	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_data;
		if (state_q == ST_USE && (hit || free_found)) begin
			stamp_q[slot] <= sec_q;
			if (!hit) key_q[slot] <= cmd_q.key;
			quota_q[slot] <= qsum - use_amt;
		end
		if (state_q == ST_QDIV && div_done) begin
			for (int i = 0; i < pcbs_pkg::MAX_CLIENTS; i++) begin
				if (valid_q[i]) quota_q[i] <= div_res[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			pool_q <= '0;
			sec_q <= '0;
			hist_q[0] <= '0;
			hist_q[1] <= '0;
			hist_q[2] <= '0;
			full_q <= 1'b0;
			grant_q <= '0;
			quota_val_q <= '0;
			avg_q <= '0;
			avg_hi_s1 <= '0;
			avg_lo_s1 <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						full_q <= 1'b0;
						grant_q <= '0;
						if (q_data.action == pcbs_pkg::ACT_USE) begin
							state_q <= ST_USE;
						end else if (q_data.now_seconds == sec_q) begin
							state_q <= ST_AVG;
						end else begin
							sec_q <= q_data.now_seconds;
							pool_q <= max_share;
							hist_q[2] <= hist_q[1];
							hist_q[1] <= hist_q[0];
							hist_q[0] <= '0;
							quota_val_q <= {3'b0, tenth_prod[63:35]};
							state_q <= ST_SWEEP;
						end
					end
				end
				ST_SWEEP: begin
					valid_q <= keep;
					// The reserve is held back only when clients remain.
					if (keep_cnt != '0) begin
						pool_q <= pool_q - quota_val_q;
						state_q <= ST_QDIV;
					end else begin
						state_q <= ST_AVG;
					end
				end
				ST_QDIV: begin
					if (div_done) state_q <= ST_AVG;
				end
				ST_USE: begin
					if (hit || free_found) begin
						valid_q[slot] <= 1'b1;
						pool_q <= pool_q - from_pool;
						hist_q[0] <= pcbs_pkg::sat_add(hist_q[0], use_amt);
						grant_q <= use_amt;
					end else begin
						full_q <= 1'b1;
					end
					state_q <= ST_AVG;
				end
				ST_AVG: begin
					avg_hi_s1 <= hi_quo;
					avg_lo_s1 <= {hi_rem, hsum[16:0]};
					state_q <= ST_AVG2;
				end
				ST_AVG2: begin
					avg_q <= avg_sum[31:0];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- hdl/per_client_bandwidth_share.sv -----
// Top level of the per-client bandwidth share block.
//  channel   direction  handshake          payload
//  command   in         start / busy       action now_seconds client_addr client_port want
//  result    out        done strobe        granted usage_average table_full
//  config    in         max_share_we       max_share_wdata
// With the back end idle, a use passes ST_USE, ST_AVG and ST_AVG2 before done,
// a new second with no clients left ST_SWEEP, ST_AVG and ST_AVG2, a repeated
// second ST_AVG and ST_AVG2; a new second with clients left also waits in ST_QDIV
// for the quota split on a serial divider. The back end takes the next beat right after.
// A two-beat queue decouples command intake from the back end; busy is high
// only when it is full. Reset clears the client table at once.
// The receiver cannot stall; each result shows for one cycle with done.
module per_client_bandwidth_share (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [31:0] now_seconds,
	input  logic [31:0] client_addr,
	input  logic [15:0] client_port,
	input  logic [31:0] want,
	output logic        done,
	output logic [31:0] granted,
	output logic [31:0] usage_average,
	output logic        table_full,
	input  logic        max_share_we,
	input  logic [31:0] max_share_wdata
);
	logic [31:0] max_share_q;
	logic q_valid, q_pop;
	pcbs_pkg::cmd_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_share_q <= '0;
		else if (max_share_we) max_share_q <= max_share_wdata;
	end

	pcbs_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .action(action),
		.now_seconds(now_seconds), .client_addr(client_addr),
		.client_port(client_port), .want(want), .busy(busy),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
	);

	pcbs_back u_back (
		.clk(clk), .arst_n(arst_n), .max_share(max_share_q),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .done(done),
		.granted(granted), .usage_average(usage_average), .table_full(table_full)
	);
endmodule

// ----- hdl/pcbs_checker.sv -----
// Port-level checker for the bandwidth share block, with its bind.
`include "per_client_bandwidth_share_assert.svh"
module pcbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        done,
	input logic [31:0] granted,
	input logic        table_full
);
	`PCBS_ASSERT_IMPL(a_full_no_grant, clk, arst_n, done && table_full, granted == 32'd0)
	`PCBS_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`PCBS_ASSERT_NEXT(a_done_spacing, clk, arst_n, done, !done [*3])
endmodule

bind per_client_bandwidth_share pcbs_checker u_pcbs_checker (
	.clk(clk), .arst_n(arst_n), .done(done),
	.granted(granted), .table_full(table_full)
);
